>>> rtl/vab_pkg.sv
package vab_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;

  localparam int ANG_FRAC  = 24;
  localparam int TABLE_LEN = 24;
  localparam int OUT_W     = 16;

  // coordinate difference, CORDIC datapath, angle accumulator, direction
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int XW     = DIFF_W + ANG_FRAC + 2;
  localparam int ZW     = 32;
  localparam int DW     = ANG_FRAC + 9;

  // lane: difference, magnitude, CORDIC steps, quadrant map; then two merge stages
  localparam int LANE_STG = CORDIC_STEPS + 3;
  localparam int NSTG     = LANE_STG + 2;

  localparam logic [DW-1:0] DEG_90  = DW'(90) << ANG_FRAC;
  localparam logic [DW-1:0] DEG_180 = DW'(180) << ANG_FRAC;
  localparam logic [DW-1:0] DEG_270 = DW'(270) << ANG_FRAC;
  localparam logic [DW-1:0] DEG_360 = DW'(360) << ANG_FRAC;
  localparam logic [OUT_W-1:0] ANGLE_MAX = OUT_W'(180) << FRAC_BITS;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115
  };

  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
  } vec_flags_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    vec_flags_t           flags;
  } cordic_t;

endpackage

>>> rtl/vector_angle_between_top.sv
// Angle between two rays sharing an apex.
// Input channel: in_valid_i / in_stall_o carry one beat of apex, first and
// second point coordinates (signed). Output channel: out_valid_o /
// out_stall_i carry angle_deg_o, unsigned degrees with 8 fraction bits,
// 0 to 180.
// Two lanes, one per ray, each form the coordinate difference, its
// magnitude, run a fully pipelined CORDIC (one stage per step) and map the
// result into its quadrant; a two-stage merge takes the folded difference.
// Throughput: one beat per cycle, except while in_stall_o is high.
// Each stage advances when it, or any stage after it, is empty, or when the
// output beat is taken, so bubbles close up while the receiver stalls; the
// input stalls only once every stage holds a beat and out_stall_i is high.
// A stalled output beat holds its value.
// Reset empties the pipeline; no beat is in flight afterwards.
module vector_angle_between_top
  import vab_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] apex_x_i,
  input  logic signed [COORD_BITS-1:0] apex_y_i,
  input  logic signed [COORD_BITS-1:0] first_x_i,
  input  logic signed [COORD_BITS-1:0] first_y_i,
  input  logic signed [COORD_BITS-1:0] second_x_i,
  input  logic signed [COORD_BITS-1:0] second_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [OUT_W-1:0]             angle_deg_o
);

  logic [NSTG-1:0] v_q, v_d;
  logic [NSTG-1:0] en;
  logic [DW-1:0]   p_dir, q_dir;

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = !out_stall_i ||
              ((v_q | ((NSTG'(1) << k) - NSTG'(1))) != {NSTG{1'b1}});
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSTG; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NSTG-1];

  vab_lane u_lane_p (
    .clk_i    (clk_i),
    .en_i     (en[LANE_STG-1:0]),
    .apex_x_i (apex_x_i),
    .apex_y_i (apex_y_i),
    .pt_x_i   (first_x_i),
    .pt_y_i   (first_y_i),
    .dir_o    (p_dir)
  );

  vab_lane u_lane_q (
    .clk_i    (clk_i),
    .en_i     (en[LANE_STG-1:0]),
    .apex_x_i (apex_x_i),
    .apex_y_i (apex_y_i),
    .pt_x_i   (second_x_i),
    .pt_y_i   (second_y_i),
    .dir_o    (q_dir)
  );

  vab_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en[NSTG-1:LANE_STG]),
    .p_dir_i (p_dir),
    .q_dir_i (q_dir),
    .angle_o (angle_deg_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_deg_o <= ANGLE_MAX)
    else $error("angle above 180 degrees");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NSTG-1] |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted beat lost at first stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((v_q == {NSTG{1'b1}}) && out_stall_i))
    else $error("input stalled while pipeline has room");
`endif

endmodule

>>> rtl/vab_lane.sv
module vab_lane
  import vab_pkg::*;
(
  input  logic                         clk_i,
  input  logic [LANE_STG-1:0]          en_i,
  input  logic signed [COORD_BITS-1:0] apex_x_i,
  input  logic signed [COORD_BITS-1:0] apex_y_i,
  input  logic signed [COORD_BITS-1:0] pt_x_i,
  input  logic signed [COORD_BITS-1:0] pt_y_i,
  output logic [DW-1:0]                dir_o
);

  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [DIFF_W-1:0]        ax, ay;
  cordic_t                  init;
  cordic_t                  st_q [CORDIC_STEPS+1];
  logic [DW-1:0]            ang;
  logic [DW-1:0]            dir_d, dir_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dx_q <= DIFF_W'(pt_x_i) - DIFF_W'(apex_x_i);
      dy_q <= DIFF_W'(pt_y_i) - DIFF_W'(apex_y_i);
    end
  end

  always_comb begin
    ax = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
    ay = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
    init.x = signed'(XW'({ax, {ANG_FRAC{1'b0}}}));
    init.y = signed'(XW'({ay, {ANG_FRAC{1'b0}}}));
    init.z = '0;
    init.flags.dx_zero = (dx_q == '0);
    init.flags.dy_zero = (dy_q == '0);
    init.flags.dx_neg  = dx_q[DIFF_W-1];
    init.flags.dy_neg  = dy_q[DIFF_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      st_q[0] <= init;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xs, ys;
    cordic_t              nxt;

    always_comb begin
      xs  = st_q[i].x >>> i;
      ys  = st_q[i].y >>> i;
      nxt = st_q[i];
      if (!st_q[i].y[XW-1]) begin
        nxt.x = st_q[i].x + ys;
        nxt.y = st_q[i].y - xs;
        nxt.z = st_q[i].z + ATAN_TAB[i];
      end else begin
        nxt.x = st_q[i].x - ys;
        nxt.y = st_q[i].y + xs;
        nxt.z = st_q[i].z - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i+2]) begin
        st_q[i+1] <= nxt;
      end
    end
  end

  // clamp to 0..90, then place in quadrant
  always_comb begin
    vec_flags_t f;
    f = st_q[CORDIC_STEPS].flags;
    if (st_q[CORDIC_STEPS].z[ZW-1]) begin
      ang = '0;
    end else if (DW'(st_q[CORDIC_STEPS].z[ZW-2:0]) > DEG_90) begin
      ang = DEG_90;
    end else begin
      ang = DW'(st_q[CORDIC_STEPS].z[ZW-2:0]);
    end
    priority if (f.dx_zero) begin
      dir_d = f.dy_neg ? DEG_270 : DEG_90;
    end else if (f.dy_zero) begin
      dir_d = f.dx_neg ? DEG_180 : '0;
    end else if (!f.dx_neg && !f.dy_neg) begin
      dir_d = ang;
    end else if (f.dx_neg && !f.dy_neg) begin
      dir_d = DEG_180 - ang;
    end else if (f.dx_neg) begin
      dir_d = DEG_180 + ang;
    end else begin
      dir_d = DEG_360 - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LANE_STG-1]) begin
      dir_q <= dir_d;
    end
  end

  assign dir_o = dir_q;

endmodule

>>> rtl/vab_merge.sv
module vab_merge
  import vab_pkg::*;
(
  input  logic              clk_i,
  input  logic [1:0]        en_i,
  input  logic [DW-1:0]     p_dir_i,
  input  logic [DW-1:0]     q_dir_i,
  output logic [OUT_W-1:0]  angle_o
);

  logic signed [DW:0] diff;
  logic [DW-1:0]      dabs_d, dabs_q;
  logic [DW-1:0]      fold;
  logic [DW:0]        rnd;
  logic [OUT_W-1:0]   angle_q;

  always_comb begin
    diff   = signed'({1'b0, q_dir_i}) - signed'({1'b0, p_dir_i});
    dabs_d = diff[DW] ? DW'(-diff) : DW'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dabs_q <= dabs_d;
    end
  end

  // fold past 180, round half up to output precision
  always_comb begin
    fold = (dabs_q > DEG_180) ? DEG_360 - dabs_q : dabs_q;
    rnd  = (DW+1)'(fold) + ((DW+1)'(1) << (ANG_FRAC - FRAC_BITS - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      angle_q <= rnd[ANG_FRAC-FRAC_BITS +: OUT_W];
    end
  end

  assign angle_o = angle_q;

`ifndef SYNTHESIS
  // data registers carry no reset; unknown until the first beat arrives
  assert property (@(posedge clk_i) $isunknown(dabs_q) || (dabs_q <= DEG_360))
    else $error("merge: direction difference out of range");
`endif

endmodule

>>> tb/sv/vector_angle_between_top_tb.sv
module vector_angle_between_top_tb;
  import vab_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int STOP_CYCLES  = 1000000;

  localparam longint H90  = longint'(90) <<< ANG_FRAC;
  localparam longint H180 = longint'(180) <<< ANG_FRAC;
  localparam longint H270 = longint'(270) <<< ANG_FRAC;
  localparam longint H360 = longint'(360) <<< ANG_FRAC;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_DEG [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t px;
    coord_t py;
    coord_t qx;
    coord_t qy;
  } query_t;

  class angle_scoreboard;
    logic [OUT_W-1:0] expected_q [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function longint quadrant_one(longint ax, longint ay);
      longint x, y, z, xs, ys;
      int i;
      x = ax <<< ANG_FRAC;
      y = ay <<< ANG_FRAC;
      z = 0;
      for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_DEG[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_DEG[i];
        end
      end
      if (z < 0) z = 0;
      if (z > H90) z = H90;
      return z;
    endfunction

    function longint heading(longint dx, longint dy);
      longint a;
      if (dx == 0) return (dy < 0) ? H270 : H90;
      if (dy == 0) return (dx < 0) ? H180 : 0;
      a = quadrant_one((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
      if (dx > 0 && dy > 0) return a;
      if (dx < 0 && dy > 0) return H180 - a;
      if (dx < 0) return H180 + a;
      return H360 - a;
    endfunction

    function logic [OUT_W-1:0] angle_between(query_t q);
      longint ax, ay, pd, qd, d, r;
      ax = q.ax;
      ay = q.ay;
      pd = heading(longint'(q.px) - ax, longint'(q.py) - ay);
      qd = heading(longint'(q.qx) - ax, longint'(q.qy) - ay);
      d = qd - pd;
      if (d < 0) d = -d;
      if (d > H180) d = H360 - d;
      r = (d + (longint'(1) <<< (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS);
      return r[OUT_W-1:0];
    endfunction

    function void note_beat(query_t q);
      expected_q.push_back(angle_between(q));
    endfunction

    function void check_beat(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (expected_q.size() == 0) begin
        $error("angle_deg: unexpected beat, expected none, actual %0d", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $error("angle_deg mismatch: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  coord_t           apex_x_i;
  coord_t           apex_y_i;
  coord_t           first_x_i;
  coord_t           first_y_i;
  coord_t           second_x_i;
  coord_t           second_y_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [OUT_W-1:0] angle_deg_o;

  angle_scoreboard sb = new();
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  logic hold_req = 1'b0;
  int   cycle_cnt = 0;

  vector_angle_between_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .apex_x_i    (apex_x_i),
    .apex_y_i    (apex_y_i),
    .first_x_i   (first_x_i),
    .first_y_i   (first_y_i),
    .second_x_i  (second_x_i),
    .second_y_i  (second_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .angle_deg_o (angle_deg_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == STOP_CYCLES) begin
      $display("vector_angle_between_top_tb NOT OK");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t apex_coord();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // points close to the apex give axis and near-diagonal rays
  function automatic coord_t point_coord(coord_t base);
    case ($urandom_range(9))
      0, 1: return base;
      2: return 16'sh7fff;
      3: return 16'sh8000;
      4, 5: return base + coord_t'($urandom_range(0, 64)) - coord_t'(32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    q.ax = apex_coord();
    q.ay = apex_coord();
    q.px = point_coord(q.ax);
    q.py = point_coord(q.ay);
    q.qx = point_coord(q.ax);
    q.qy = point_coord(q.ay);
    case ($urandom_range(19))
      0, 1: begin
        q.qx = q.px;
        q.qy = q.py;
      end
      2: begin
        q.qx = coord_t'(2 * q.ax - q.px);
        q.qy = coord_t'(2 * q.ay - q.py);
      end
      default: ;
    endcase
    return q;
  endfunction

  // returns at the rising edge that took the beat, or after the idle gap
  task automatic send_query(input query_t q);
    logic go;
    int   gap;
    in_valid_i <= 1'b1;
    apex_x_i   <= q.ax;
    apex_y_i   <= q.ay;
    first_x_i  <= q.px;
    first_y_i  <= q.py;
    second_x_i <= q.qx;
    second_y_i <= q.qy;
    do begin
      @(negedge clk_i);
      go = !in_stall_o;
      if (go) sb.note_beat(q);
      @(posedge clk_i);
    end while (!go);
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_points(input int ax, ay, px, py, qx, qy);
    query_t q;
    q.ax = coord_t'(ax);
    q.ay = coord_t'(ay);
    q.px = coord_t'(px);
    q.py = coord_t'(py);
    q.qx = coord_t'(qx);
    q.qy = coord_t'(qy);
    send_query(q);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(angle_deg_o);
  end

  initial begin
    int hold;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        hold = rx_quiet ? 0 : idle_len();
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (rx_quiet ? 8 : $urandom_range(1, 4)) @(posedge clk_i);
    end
  end

  initial begin
    int n;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    apex_x_i   = '0;
    apex_y_i   = '0;
    first_x_i  = '0;
    first_y_i  = '0;
    second_x_i = '0;
    second_y_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cases, starting with both rays of zero length
    send_points(0, 0, 0, 0, 0, 0);
    send_points(0, 0, 1, 0, -1, 0);
    send_points(0, 0, 0, 1, 0, -1);
    send_points(0, 0, 1, 1, -1, -1);
    send_points(0, 0, 1, -1, 1, 1);
    send_points(0, 0, -1, 1, 1, -1);
    send_points(-32768, -32768, 32767, 32767, 32767, -32768);
    send_points(32767, 32767, -32768, -32768, -32768, 32767);
    send_points(32767, -32768, -32768, 32767, 32767, 32767);
    send_points(-32768, 32767, 32767, -32768, -32768, -32768);
    send_points(7, 7, 7, 7, 7, 2);
    send_points(0, 0, 1, 32767, 32767, 1);
    send_points(0, 0, -32768, 1, -32768, -1);
    send_points(0, 0, 3, 4, -4, 3);
    send_points(0, 0, 1, 0, 1, -1);
    send_points(0, 0, -1, 0, 0, -1);
    send_points(0, 0, 32767, -1, 32767, 1);
    send_points(0, 0, 100, 200, 100, 200);
    send_points(100, -100, 100, -100, 100, 500);
    send_points(0, 0, -32768, -32768, 32767, -32768);
    send_points(-5, 9, -32768, 9, 32767, 8);

    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 250 == 0) begin
        tx_quiet = ((n / 250) % 4 == 1);
        rx_quiet = ((n / 250) % 4 == 1) || ((n / 250) % 4 == 2);
      end
      // long receiver hold-off while beats keep coming
      if (n == 600) begin
        hold_req = 1'b1;
        tx_quiet = 1'b1;
      end
      if (n == 1200) begin
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      send_query(random_query());
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("vector_angle_between_top_tb OK");
    end else begin
      $display("vector_angle_between_top_tb NOT OK");
    end
    $finish;
  end

endmodule
